/* design/dual_lcg_random_generator_macros.svh */
// ============================================================================
// Assertion macros for the dual LCG random generator
// Shorthand for clocked implication checks; every user has i_clk and i_rst_n.
// ============================================================================
`ifndef DUAL_LCG_RANDOM_GENERATOR_MACROS_SVH
`define DUAL_LCG_RANDOM_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define DLCG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define DLCG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* design/dlcg_pkg.sv */
// ============================================================================
// dlcg_pkg
// Types and constants shared by the dual LCG generator modules.
// ============================================================================
`default_nettype none

package dlcg_pkg;

    // Operation codes carried on the input tuser
    localparam logic OP_DRAW   = 1'b0;
    localparam logic OP_RESEED = 1'b1;

    // Generator constants
    localparam logic [63:0] DISTORT_A  = 64'h6a09e667f3bcc908;
    localparam logic [63:0] DISTORT_B  = 64'hbb67ae8584caa73b;
    localparam logic [31:0] SPREAD_MUL = 32'hCE95CE95;
    localparam logic [39:0] A_ONE      = 40'd777206658847;
    localparam logic [39:0] A_TWO      = 40'd603803122327;
    localparam logic [47:0] INC_ONE    = 48'd13;
    localparam logic [47:0] INC_TWO    = 48'd257;

    // Partial product steps of the 48-bit modular multiply
    localparam logic [1:0] STEP_LL = 2'd0;  // x_lo * c_lo + addend
    localparam logic [1:0] STEP_HL = 2'd1;  // + (x_hi * c_lo) << 24
    localparam logic [1:0] STEP_LH = 2'd2;  // + (x_lo * c_hi) << 24

    // Operand sources for the two multiply lanes
    typedef enum logic [1:0] {
        LD_SEED = 2'd0,
        LD_ADV  = 2'd1,
        LD_MIX  = 2'd2
    } t_ld_mode;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic     cap_seed;
        logic     seed_one;
        logic     seed_mul;
        logic     stretch;
        logic     load;
        t_ld_mode load_mode;
        logic     step_en;
        logic [1:0] step;
        logic     emit;
        logic     commit;
    } t_dp_cmd;

    function automatic logic [63:0] stretch64(input logic [63:0] v);
        logic [63:0] r11;
        logic [63:0] r17;
        logic [63:0] r23;
        logic [63:0] r31;
        r11 = {v[52:0], v[63:53]};
        r17 = {v[46:0], v[63:47]};
        r23 = {v[40:0], v[63:41]};
        r31 = {v[32:0], v[63:33]};
        return (r11 ^ r17) + (r23 ^ r31);
    endfunction

    // Low 48 bits of (v >> 32) ^ v
    function automatic logic [47:0] fold48(input logic [63:0] v);
        return v[47:0] ^ {16'h0000, v[63:32]};
    endfunction

endpackage

`default_nettype wire

/* design/dlcg_mul48.sv */
// ============================================================================
// dlcg_mul48
// One multiply lane: x * c + addend modulo 2^48 over three 24x24 steps.
// ============================================================================
`default_nettype none

module dlcg_mul48
    import dlcg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_load,
    input  wire logic [47:0] i_x,
    input  wire logic [39:0] i_c,
    input  wire logic [47:0] i_add,
    input  wire logic        i_step_en,
    input  wire logic [1:0]  i_step,
    output logic      [47:0] o_acc
);

    logic [47:0] r_x;
    logic [39:0] r_c;
    logic [47:0] r_add;
    logic [47:0] r_acc;

    logic [23:0] w_a;
    logic [23:0] w_b;
    logic [47:0] w_p;

    // The x_hi * c_hi term falls entirely above bit 47 and is never formed
    assign w_a = (i_step == STEP_HL) ? r_x[47:24] : r_x[23:0];
    assign w_b = (i_step == STEP_LH) ? {8'h00, r_c[39:24]} : r_c[23:0];
    assign w_p = {24'h000000, w_a} * {24'h000000, w_b};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x   <= i_x;
            r_c   <= i_c;
            r_add <= i_add;
        end
        if (i_step_en) begin
            case (i_step)
                STEP_LL: r_acc <= w_p + r_add;
                STEP_HL: r_acc <= r_acc + {w_p[23:0], 24'h000000};
                STEP_LH: r_acc <= r_acc + {w_p[23:0], 24'h000000};
                default: r_acc <= r_acc;
            endcase
        end
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

/* design/dlcg_dp.sv */
// ============================================================================
// dlcg_dp
// Datapath: state registers, seed spreading and two multiply lanes.
// ============================================================================
`default_nettype none

module dlcg_dp
    import dlcg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire t_dp_cmd     i_cmd,
    input  wire logic [31:0] i_seed,
    output logic      [30:0] o_random
);

    logic [47:0] r_first;
    logic [47:0] r_second;
    logic [31:0] r_seed;
    logic [63:0] r_m;
    logic [63:0] r_s;
    logic [30:0] r_out;

    logic [63:0] w_smul;
    logic [47:0] w_acc_a;
    logic [47:0] w_acc_b;
    logic [47:0] w_x_a;
    logic [47:0] w_x_b;
    logic [39:0] w_c_a;
    logic [39:0] w_c_b;
    logic [47:0] w_add_a;
    logic [47:0] w_add_b;

    assign w_smul = {32'h00000000, r_seed} * {32'h00000000, SPREAD_MUL};

    // Lane A produces the first state, lane B the second
    always_comb begin
        case (i_cmd.load_mode)
            LD_SEED: begin
                w_x_a   = fold48(r_s ^ DISTORT_A);
                w_c_a   = A_TWO;
                w_add_a = INC_ONE;
                w_x_b   = fold48(r_s ^ DISTORT_B);
                w_c_b   = A_ONE;
                w_add_b = INC_TWO;
            end
            LD_MIX: begin
                w_x_a   = w_acc_b;
                w_c_a   = A_ONE;
                w_add_a = r_first;
                w_x_b   = w_acc_a;
                w_c_b   = A_TWO;
                w_add_b = INC_ONE;
            end
            default: begin
                w_x_a   = r_first;
                w_c_a   = A_ONE;
                w_add_a = INC_ONE;
                w_x_b   = r_second;
                w_c_b   = A_TWO;
                w_add_b = INC_ONE;
            end
        endcase
    end

    dlcg_mul48 u_lane_a (
        .i_clk     (i_clk),
        .i_load    (i_cmd.load),
        .i_x       (w_x_a),
        .i_c       (w_c_a),
        .i_add     (w_add_a),
        .i_step_en (i_cmd.step_en),
        .i_step    (i_cmd.step),
        .o_acc     (w_acc_a)
    );

    dlcg_mul48 u_lane_b (
        .i_clk     (i_clk),
        .i_load    (i_cmd.load),
        .i_x       (w_x_b),
        .i_c       (w_c_b),
        .i_add     (w_add_b),
        .i_step_en (i_cmd.step_en),
        .i_step    (i_cmd.step),
        .o_acc     (w_acc_b)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.seed_one) begin
            r_seed <= 32'd1;
        end else if (i_cmd.cap_seed) begin
            r_seed <= i_seed;
        end
        if (i_cmd.seed_mul) begin
            r_m <= w_smul;
        end
        if (i_cmd.stretch) begin
            r_s <= stretch64(r_m);
        end
        if (i_cmd.emit) begin
            r_out <= w_acc_a[47:17] ^ w_acc_b[47:17];
        end
        if (i_cmd.commit) begin
            r_first  <= w_acc_a;
            r_second <= w_acc_b;
        end
    end

    assign o_random = r_out;

endmodule

`default_nettype wire

/* design/dlcg_ctrl.sv */
// ============================================================================
// dlcg_ctrl
// Controller: sequences reseeds and draws, owns both stream handshakes.
// ============================================================================
`default_nettype none

`include "dual_lcg_random_generator_macros.svh"

module dlcg_ctrl
    import dlcg_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_s_axis_tvalid,
    input  wire logic i_op,
    output logic      o_s_axis_tready,
    output logic      o_m_axis_tvalid,
    input  wire logic i_m_axis_tready,
    output t_dp_cmd   o_cmd
);

    typedef enum logic [7:0] {
        ST_INIT   = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_SMUL   = 8'b0000_0100,
        ST_STR    = 8'b0000_1000,
        ST_LOAD   = 8'b0001_0000,
        ST_MUL    = 8'b0010_0000,
        ST_EMIT   = 8'b0100_0000,
        ST_COMMIT = 8'b1000_0000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_step,  n_step;
    logic       r_draw,  n_draw;
    logic       r_phase, n_phase;
    logic       r_valid, n_valid;
    t_dp_cmd    w_cmd;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_draw  = r_draw;
        n_phase = r_phase;
        w_cmd   = '0;
        w_cmd.load_mode = !r_draw ? LD_SEED : (r_phase ? LD_MIX : LD_ADV);
        w_cmd.step      = r_step;
        case (r_state)
            ST_INIT: begin
                w_cmd.seed_one = 1'b1;
                n_draw  = 1'b0;
                n_state = ST_SMUL;
            end
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    w_cmd.cap_seed = 1'b1;
                    n_draw  = (i_op == OP_DRAW);
                    n_phase = 1'b0;
                    n_state = (i_op == OP_DRAW) ? ST_LOAD : ST_SMUL;
                end
            end
            ST_SMUL: begin
                w_cmd.seed_mul = 1'b1;
                n_state = ST_STR;
            end
            ST_STR: begin
                w_cmd.stretch = 1'b1;
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                w_cmd.load = 1'b1;
                n_step  = STEP_LL;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                w_cmd.step_en = 1'b1;
                if (r_step == STEP_LH) begin
                    n_state = (r_draw && !r_phase) ? ST_EMIT : ST_COMMIT;
                end else begin
                    n_step = r_step + 2'd1;
                end
            end
            ST_EMIT: begin
                // Hold until the output register is free or draining
                if (!r_valid || i_m_axis_tready) begin
                    w_cmd.emit = 1'b1;
                    n_phase = 1'b1;
                    n_state = ST_LOAD;
                end
            end
            ST_COMMIT: begin
                w_cmd.commit = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
        if (w_cmd.emit) begin
            n_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_step  <= STEP_LL;
            r_draw  <= 1'b0;
            r_phase <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_draw  <= n_draw;
            r_phase <= n_phase;
            r_valid <= n_valid;
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_valid;
    assign o_cmd           = w_cmd;

    `DLCG_ASSERT_IMP(a_emit_slot_free, w_cmd.emit, !r_valid || i_m_axis_tready, "emit over a pending result")
    `DLCG_ASSERT_NEXT(a_emit_sets_valid, w_cmd.emit, o_m_axis_tvalid, "emitted result not presented")
    `DLCG_ASSERT_IMP(a_idle_no_update, o_s_axis_tready, !(w_cmd.step_en || w_cmd.commit), "datapath busy while idle")
    `DLCG_ASSERT_IMP(a_step_range, r_state == ST_MUL, r_step == STEP_LL || r_step == STEP_HL || r_step == STEP_LH, "bad multiply step")

endmodule

`default_nettype wire

/* design/dual_lcg_random_generator.sv */
// ============================================================================
// dual_lcg_random_generator
// Pseudo-random source built from two cross-mixed 48-bit LCG states.
// ============================================================================
// An input item with tuser = 0 draws one 31-bit value (one output item);
// tuser = 1 reseeds both states from the 32-bit seed in tdata and produces
// no output. The block works on one item at a time. Each 48-bit modular
// product is built from three 24x24 partial products in a lane, two lanes
// run side by side, and a draw needs two rounds of products (advance, then
// cross-mix) where a reseed needs one plus a 32x32 seed multiply and a
// stretch step. The value of a draw is presented after the advance round;
// if the previous value has still not been taken by then, the draw holds
// until it is. After reset the block reseeds itself with seed 1, so the
// input is not ready until that reseed is done. A finished value waits in
// an output register while the next item is taken in.
// ============================================================================
`default_nettype none

module dual_lcg_random_generator
    import dlcg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,   // [31:0] seed
    input  wire logic [0:0]  i_s_axis_tuser,   // [0] operation (0 draw, 1 reseed)
    // Output stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [31:0] o_m_axis_tdata    // [30:0] random_value, [31] zero
);

    t_dp_cmd     w_cmd;
    logic [30:0] w_random;

    // Sequencer: decides which datapath step runs each cycle
    dlcg_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_op            (i_s_axis_tuser[0]),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_cmd           (w_cmd)
    );

    // Arithmetic: states, seed spreading, multiply lanes, output register
    dlcg_dp u_dp (
        .i_clk    (i_clk),
        .i_cmd    (w_cmd),
        .i_seed   (i_s_axis_tdata),
        .o_random (w_random)
    );

    // Pad the 31-bit value to a whole number of bytes
    assign o_m_axis_tdata = {1'b0, w_random};

endmodule

`default_nettype wire

/* sim/tb.sv */
// ============================================================================
// tb
// Self-checking bench for dual_lcg_random_generator. Items go in on the input
// stream with random gaps, results are taken with random stalls, and every
// draw is compared with a value predicted from a local copy of both states.
// ============================================================================
module tb;
    import dlcg_pkg::*;

    // Generator arithmetic, kept apart from the package on purpose
    localparam logic [63:0] SEED_SPREAD = 64'h00000000CE95CE95;
    localparam logic [63:0] SALT_FIRST  = 64'h6a09e667f3bcc908;
    localparam logic [63:0] SALT_SECOND = 64'hbb67ae8584caa73b;
    localparam logic [47:0] MULT_ONE    = 48'd777206658847;
    localparam logic [47:0] MULT_TWO    = 48'd603803122327;
    localparam logic [47:0] STEP_INC    = 48'd13;
    localparam logic [47:0] SECOND_INC  = 48'd257;

    localparam int RANDOM_ITEMS   = 1900;
    localparam int SEGMENT_ITEMS  = 160;   // items per idling pattern
    localparam int MAX_GAP        = 5;
    localparam int DRAIN_CYCLES   = 24;    // wait for a late or stray result
    localparam int WATCHDOG_LIMIT = 1000;  // quiet cycles before giving up
    localparam int MAX_REPORTS    = 10;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata  = '0;    // [31:0] seed
    logic [0:0]  i_s_axis_tuser  = '0;    // [0] operation
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;          // [30:0] random_value, [31] zero

    // Predicted generator state
    logic [47:0] state_one;
    logic [47:0] state_two;

    // Draw values still owed by the block, oldest first
    logic [30:0] pending_draws[$];

    bit tx_idle      = 1'b0;
    bit rx_idle      = 1'b0;
    bit result_taken = 1'b0;
    int sink_stall   = 0;
    int error_count  = 0;
    int draws_seen   = 0;
    int quiet_cycles = 0;

    dual_lcg_random_generator u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic logic [63:0] rotate_left(input logic [63:0] v, input int n);
        return (v << n) | (v >> (64 - n));
    endfunction

    // Fold the high word into the low one, then scale and offset mod 2^48
    function automatic logic [47:0] fold_and_scale(input logic [63:0] v,
                                                   input logic [47:0] mul,
                                                   input logic [47:0] add);
        logic [63:0] folded;
        folded = (v >> 32) ^ v;
        return folded[47:0] * mul + add;
    endfunction

    task automatic reseed_states(input logic [31:0] seed);
        logic [63:0] spread;
        logic [63:0] mixed;
        spread = {32'd0, seed} * SEED_SPREAD;
        mixed  = (rotate_left(spread, 11) ^ rotate_left(spread, 17))
               + (rotate_left(spread, 23) ^ rotate_left(spread, 31));
        state_one = fold_and_scale(mixed ^ SALT_FIRST, MULT_TWO, STEP_INC);
        state_two = fold_and_scale(mixed ^ SALT_SECOND, MULT_ONE, SECOND_INC);
    endtask

    // Advance both states, take bits 47..17 of their XOR, then cross-mix
    task automatic draw_next(output logic [30:0] value);
        logic [47:0] prior;
        logic [47:0] adv_one;
        logic [47:0] adv_two;
        logic [47:0] mixed;
        prior   = state_one;
        adv_one = prior * MULT_ONE + STEP_INC;
        adv_two = state_two * MULT_TWO + STEP_INC;
        mixed   = adv_one ^ adv_two;
        value   = mixed[47:17];
        state_one = adv_two * MULT_ONE + prior;
        state_two = adv_one * MULT_TWO + STEP_INC;
    endtask

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    // Present one item after an optional gap and hold it until accepted.
    // Valid stays high into the next call, so back-to-back items never
    // drop it for a cycle.
    task automatic send_item(input logic op, input logic [31:0] seed);
        int gap;
        logic [30:0] value;
        gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid   <= 1'b1;
        i_s_axis_tdata    <= seed;
        i_s_axis_tuser[0] <= op;
        // Sample ready as it stood before the edge
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (op == OP_RESEED) begin
            reseed_states(seed);
        end else begin
            draw_next(value);
            pending_draws.push_back(value);
        end
    endtask

    task automatic stop_input();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_until_drained();
        stop_input();
        while (pending_draws.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------------
    // Draw a fresh stall after each taken result; hold ready high otherwise
    initial begin
        forever begin
            @(negedge i_clk);
            if (result_taken) begin
                result_taken = 1'b0;
                sink_stall   = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (sink_stall > 0) begin
                i_m_axis_tready <= 1'b0;
                sink_stall--;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("draw %0d: %s, expected %h, got %h", draws_seen, what, want, got);
        end
    endtask

    // Compare each taken result with the oldest pending draw
    always @(posedge i_clk) begin
        logic [31:0] want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            result_taken = 1'b1;
            if (pending_draws.size() == 0) begin
                report_mismatch("unexpected result", 32'h0, o_m_axis_tdata);
            end else begin
                want = {1'b0, pending_draws.pop_front()};
                if (o_m_axis_tdata !== want) begin
                    report_mismatch("wrong random_value", want, o_m_axis_tdata);
                end
            end
            draws_seen++;
        end
    end

    // End the run if neither side moves an item for too long
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("dual_lcg_random_generator: mismatch");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Draws straight after reset expose the seed-one start state
    task automatic test_reset_state();
        send_item(OP_DRAW, 32'h0000_0000);
        send_item(OP_DRAW, 32'hFFFF_FFFF);
        send_item(OP_DRAW, 32'h0000_0001);
    endtask

    // Extreme seeds; each draw carries the inverted seed, which must be ignored
    task automatic test_reseed_extremes();
        logic [31:0] seeds[4];
        seeds = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000};
        foreach (seeds[k]) begin
            send_item(OP_RESEED, seeds[k]);
            send_item(OP_DRAW, ~seeds[k]);
        end
    endtask

    // Only the second of two adjacent reseeds should count
    task automatic test_back_to_back_reseeds();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_item(OP_RESEED, 32'hAAAA_AAAA);
        send_item(OP_RESEED, 32'h5555_5555);
        send_item(OP_DRAW, 32'h7FFF_FFFF);
        send_item(OP_DRAW, 32'h0000_0000);
    endtask

    // Let the block run dry, then pick up again from an idle state
    task automatic test_pause_until_drained();
        send_item(OP_DRAW, $urandom);
        send_item(OP_DRAW, $urandom);
        wait_until_drained();
        send_item(OP_RESEED, $urandom);
        send_item(OP_DRAW, $urandom);
        wait_until_drained();
    endtask

    // Mostly draws with the odd reseed; cycle through idling patterns
    task automatic test_random_traffic();
        int n;
        int pattern;
        logic op;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % SEGMENT_ITEMS == 0) begin
                pattern = (n / SEGMENT_ITEMS) % 4;
                tx_idle = pattern[0];
                rx_idle = pattern[1];
            end
            if (n == RANDOM_ITEMS / 2) begin
                wait_until_drained();
            end
            op = ($urandom_range(0, 9) == 0) ? OP_RESEED : OP_DRAW;
            send_item(op, $urandom);
        end
    endtask

    initial begin
        reseed_states(32'd1);
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_reseed_extremes();
        test_back_to_back_reseeds();
        test_pause_until_drained();
        test_random_traffic();

        // Drain, then give a late or stray result time to show up
        stop_input();
        while (pending_draws.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("dual_lcg_random_generator: match");
        end else begin
            $display("dual_lcg_random_generator: mismatch");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/dlcg_pkg.sv
design/dlcg_mul48.sv
design/dlcg_dp.sv
design/dlcg_ctrl.sv
design/dual_lcg_random_generator.sv
sim/tb.sv
